// File: hw/rtl/bba_pkg.sv
// Shared constants of the bitmap block allocator: field widths, command
// codes and register indexes. No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int IDX_W = 10;   // width of the request and result block fields
    localparam int CNT_W = 11;   // block_count register width
    localparam int APB_AW = 3;   // byte address width of the register port
    localparam int APB_DW = 32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // register index, taken from paddr[2] (one 32-bit register per word)
    localparam logic REG_BLOCK_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

endpackage

// File: hw/rtl/bitmap_block_allocator.sv
// Bitmap block allocator top level: usage bitmap in one synchronous RAM,
// word scan for allocate, read-modify-write for free, APB register port.
// Depends on bba_pkg.
`timescale 1ns / 1ps

//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  request  | i_in_valid, o_in_ready, i_cmd, i_target_blk    | in
//  result   | o_out_valid, i_out_ready, o_block_index, o_ok  | out
//  config   | psel, penable, pwrite, paddr, pwdata, prdata,  | in/out
//           | pready (block_count at byte address 0)         |
//
// Order: an allocate reads one RAM word per cycle from word 0 and checks each
// word as it returns; a failed scan reads every word below the count (none
// with a zero count). A free in range reads its word, then writes it back;
// one out of range goes straight to the result. The next request may be
// taken from the cycle in which the result shows in the output register.
// Reset: after reset the RAM is cleared one word per cycle, while no request
// is taken; register writes are taken throughout.
// Stalls: one request is in work at a time; a finished result waits in the
// output register and the next request may be taken meanwhile; while that
// register is full and not drained, the finished result holds the input off.

module bitmap_block_allocator #(
    parameter int unsigned MAX_BLOCKS = 1024,
    parameter int unsigned WORD_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_cmd,
    input  logic [bba_pkg::IDX_W-1:0]    i_target_blk,
    // result
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bba_pkg::IDX_W-1:0]    o_block_index,
    output logic                         o_ok,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bba_pkg::APB_AW-1:0]   paddr,
    input  logic [bba_pkg::APB_DW-1:0]   pwdata,
    output logic [bba_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    import bba_pkg::*;

    localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    localparam int LW    = (CW > CNT_W) ? CW : CNT_W;   // effective count width
    localparam int BSW   = LW + 1;                       // word base, may pass count
    // block / WORD_BITS by reciprocal; exact for 10-bit blocks at this shift
    localparam int RSH   = 20;
    localparam int RW    = 21;
    localparam int unsigned RECIP = ((1 << RSH) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_FRD  = 3'd3;
    localparam logic [2:0] ST_FWR  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [2:0]           r_state, n_state;
    logic [AW-1:0]        r_word, n_word;      // next word to read / clear
    logic [BSW-1:0]       r_base, n_base;      // first block of r_word
    logic                 r_rv, n_rv;          // read data belongs to the scan
    logic [AW-1:0]        r_rword, n_rword;
    logic [BSW-1:0]       r_rbase, n_rbase;
    logic [LW-1:0]        r_lim, n_lim;
    logic [IDX_W-1:0]     r_blk, n_blk;
    logic [IDX_W-1:0]     r_fq, n_fq;          // word of the block to free
    logic [IDX_W-1:0]     r_res_idx, n_res_idx;
    logic                 r_res_ok, n_res_ok;
    logic                 r_out_valid, n_out_valid;
    logic [IDX_W-1:0]     r_out_idx, n_out_idx;
    logic                 r_out_ok, n_out_ok;
    logic [CNT_W-1:0]     r_block_count;

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    // RAM controls
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic [AW-1:0]        w_raddr;
    logic                 w_re;

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    logic w_cfg_wr;
    assign w_cfg_wr = psel && penable && pwrite && paddr[2] == REG_BLOCK_COUNT;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_BLOCK_COUNT) ?
                      {{(APB_DW-CNT_W){1'b0}}, r_block_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BLOCK_COUNT_RST;
        end else if (w_cfg_wr) begin
            r_block_count <= pwdata[CNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    // effective count: saturate at MAX_BLOCKS
    logic [LW-1:0] w_lim;
    assign w_lim = (LW'(r_block_count) > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS)
                                                          : LW'(r_block_count);

    // word of the incoming block number
    logic [IDX_W+RW-1:0] w_prod;
    assign w_prod = {{RW{1'b0}}, i_target_blk} * (IDX_W + RW)'(RECIP);

    // bit of the block to free inside its word
    logic [15:0]   w_fprod;
    logic [15:0]   w_frem;
    logic [BW-1:0] w_fbit;
    assign w_fprod = 16'(r_fq) * 16'(WORD_BITS);
    assign w_frem  = 16'(r_blk) - w_fprod;
    assign w_fbit  = w_frem[BW-1:0];

    // scan: treat bits at or above the count as in use, find the lowest clear
    logic [BSW-1:0]       w_rem;
    logic [WORD_BITS-1:0] w_masked;
    logic [BW-1:0]        w_ff;
    logic                 w_found;
    logic                 w_hit;
    logic                 w_more;

    assign w_rem = BSW'(r_lim) - r_rbase;

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            w_masked[b] = r_rdata[b] | !(BSW'(b) < w_rem);
        end
    end

    always_comb begin
        w_ff    = '0;
        w_found = 1'b0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!w_masked[b]) begin
                w_ff    = BW'(b);
                w_found = 1'b1;
            end
        end
    end

    assign w_hit  = (r_state == ST_SCAN) && r_rv && w_found;
    assign w_more = r_base < BSW'(r_lim);

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    logic w_slot_free;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_base      = r_base;
        n_rv        = 1'b0;
        n_rword     = r_word;
        n_rbase     = r_base;
        n_lim       = r_lim;
        n_blk       = r_blk;
        n_fq        = r_fq;
        n_res_idx   = r_res_idx;
        n_res_ok    = r_res_ok;
        n_out_valid = i_out_ready ? 1'b0 : r_out_valid;
        n_out_idx   = r_out_idx;
        n_out_ok    = r_out_ok;
        w_we        = 1'b0;
        w_waddr     = r_word;
        w_wdata     = '0;
        w_raddr     = r_word;
        w_re        = 1'b0;

        case (r_state)
            ST_CLR: begin
                // sweep zeros through the bitmap
                w_we   = 1'b1;
                n_word = r_word + 1'b1;
                if (r_word == AW'(WORDS - 1)) begin
                    n_word  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_lim  = w_lim;
                    n_blk  = i_target_blk;
                    n_fq   = w_prod[RSH +: IDX_W];
                    n_word = '0;
                    n_base = '0;
                    if (i_cmd == CMD_ALLOC) begin
                        n_state = ST_SCAN;
                    end else if (LW'(i_target_blk) < w_lim) begin
                        n_state = ST_FRD;
                    end else begin
                        // out of range: echo the block, change nothing
                        n_res_idx = i_target_blk;
                        n_res_ok  = 1'b0;
                        n_state   = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                // issue one word per cycle, check the word read last cycle
                w_re    = w_more;
                n_rv    = w_more && !w_hit;
                n_rword = r_word;
                n_rbase = r_base;
                if (w_more) begin
                    n_word = r_word + 1'b1;
                    n_base = r_base + BSW'(WORD_BITS);
                end
                if (w_hit) begin
                    w_we      = 1'b1;
                    w_waddr   = r_rword;
                    w_wdata   = r_rdata | (WORD_BITS'(1) << w_ff);
                    n_res_idx = IDX_W'(r_rbase + BSW'(w_ff));
                    n_res_ok  = 1'b1;
                    n_state   = ST_DONE;
                end else if (!r_rv && !w_more) begin
                    // nothing free below the count
                    n_res_idx = '0;
                    n_res_ok  = 1'b0;
                    n_state   = ST_DONE;
                end
            end
            ST_FRD: begin
                w_raddr = AW'(r_fq);
                w_re    = 1'b1;
                n_state = ST_FWR;
            end
            ST_FWR: begin
                w_we      = 1'b1;
                w_waddr   = AW'(r_fq);
                w_wdata   = r_rdata & ~(WORD_BITS'(1) << w_fbit);
                n_res_idx = r_blk;
                n_res_ok  = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_res_idx;
                    n_out_ok    = r_res_ok;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_word      <= '0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_rv        <= n_rv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base    <= n_base;
        r_rword   <= n_rword;
        r_rbase   <= n_rbase;
        r_lim     <= n_lim;
        r_blk     <= n_blk;
        r_fq      <= n_fq;
        r_res_idx <= n_res_idx;
        r_res_ok  <= n_res_ok;
        r_out_idx <= n_out_idx;
        r_out_ok  <= n_out_ok;
    end

    // bitmap RAM, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_out_valid   = r_out_valid;
    assign o_block_index = r_out_idx;
    assign o_ok          = r_out_ok;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // one request at a time: a transfer drops ready for the next cycle
    a_one_in_work : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in work");

    // a write-back never collides with a read of the same word
    a_no_rw_clash : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re && w_waddr == w_raddr))
        else $error("RAM read and write to the same word in one cycle");

    // a successful allocate reports a block below the effective count
    a_alloc_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> (r_rbase + BSW'(w_ff)) < BSW'(r_lim))
        else $error("allocate found a block at or above the count");

endmodule

// File: bench/bba_grant_checker.sv
// Transfer monitor and result checker for the bitmap block allocator.
// Mirrors the usage bitmap and block_count, predicts each grant and compares.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_grant_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_cmd,
    input  logic [bba_pkg::IDX_W-1:0]    i_target_blk,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [bba_pkg::IDX_W-1:0]    i_block_index,
    input  logic                         i_ok,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [bba_pkg::APB_AW-1:0]   i_paddr,
    input  logic [bba_pkg::APB_DW-1:0]   i_pwdata,
    input  logic [bba_pkg::APB_DW-1:0]   i_prdata,
    input  logic                         i_pready,
    output int unsigned                  o_mismatch_count,
    output int unsigned                  o_pending
);
    import bba_pkg::*;

    localparam int unsigned MAP_BITS = 1 << IDX_W;

    typedef struct packed {
        logic [IDX_W-1:0] block_index;
        logic             ok;
    } t_grant;

    logic [MAP_BITS-1:0] usage_map = '0;
    logic [CNT_W-1:0]    block_count = BLOCK_COUNT_RST;
    t_grant              grants_due[$];
    int unsigned         mismatch_count = 0;
    int unsigned         pending_count = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_pending        = pending_count;

    // Serve one request against the mirrored bitmap and return the grant.
    function automatic t_grant serve_request(input logic cmd, input logic [IDX_W-1:0] blk);
        int unsigned limit;
        t_grant      g;
        limit = (block_count > MAP_BITS) ? MAP_BITS : block_count;
        g = '0;
        if (cmd == CMD_ALLOC) begin
            for (int unsigned b = 0; b < limit; b++) begin
                if (!usage_map[b]) begin
                    usage_map[b] = 1'b1;
                    g.block_index = IDX_W'(b);
                    g.ok = 1'b1;
                    break;
                end
            end
        end else begin
            g.block_index = blk;
            if (blk < limit) begin
                usage_map[blk] = 1'b0;
                g.ok = 1'b1;
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            usage_map = '0;
            block_count = BLOCK_COUNT_RST;
            grants_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (grants_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none expected: index %0d ok %0b",
                             $time, i_block_index, i_ok);
                end else begin
                    want = grants_due.pop_front();
                    if (i_block_index !== want.block_index) begin
                        mismatch_count++;
                        $display("%0t: block_index expected %0d actual %0d",
                                 $time, want.block_index, i_block_index);
                    end
                    if (i_ok !== want.ok) begin
                        mismatch_count++;
                        $display("%0t: ok expected %0b actual %0b", $time, want.ok, i_ok);
                    end
                end
            end
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_BLOCK_COUNT) begin
                if (i_pwrite) begin
                    block_count = i_pwdata[CNT_W-1:0];
                end else if (i_prdata !== APB_DW'(block_count)) begin
                    mismatch_count++;
                    $display("%0t: block_count readback expected %0d actual %0d",
                             $time, block_count, i_prdata);
                end
            end
            if (i_in_valid && i_in_ready)
                grants_due.push_back(serve_request(i_cmd, i_target_blk));
        end
        pending_count = grants_due.size();
    end

endmodule

// File: bench/testbench.sv
// Top of the bitmap block allocator bench: clock, reset, request and register
// stimulus, result-side stalls and the verdict. Depends on bba_pkg, the
// allocator RTL and bba_grant_checker.
`timescale 1ns / 1ps

module testbench;
    import bba_pkg::*;

    localparam logic [APB_AW-1:0] BLOCK_COUNT_ADDR = {REG_BLOCK_COUNT, 2'b00};
    localparam int unsigned PHASES = 14;
    localparam int unsigned PHASE_ITEMS = 100;

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               cmd = CMD_ALLOC;
    logic [IDX_W-1:0]   target_blk = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [IDX_W-1:0]   block_index;
    logic               ok;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int unsigned        mismatch_count;
    int unsigned        pending;

    // Per-phase switches: a quiet side never idles, giving back-to-back stretches.
    bit                 tx_quiet = 1'b0;
    bit                 rx_quiet = 1'b0;
    bit                 result_taken = 1'b0;
    int unsigned        stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bitmap_block_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_cmd          (cmd),
        .i_target_blk   (target_blk),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_block_index  (block_index),
        .o_ok           (ok),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    bba_grant_checker grant_check (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_cmd            (cmd),
        .i_target_blk     (target_blk),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_block_index    (block_index),
        .i_ok             (ok),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_prdata         (prdata),
        .i_pready         (pready),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    // Result side: after each transfer draw a stall and hold ready low that long.
    always @(posedge i_clk) result_taken <= out_valid && out_ready;

    always @(negedge i_clk) begin
        if (result_taken)
            stall_left = rx_quiet ? 0 : $urandom_range(0, 8);
        if (stall_left != 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Drive one request after a random gap; hold it until the transfer.
    // Entered and left at a falling edge, so valid stays up for back-to-back items.
    task automatic send_request(input logic op, input logic [IDX_W-1:0] blk);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        cmd = op;
        target_blk = blk;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted grant has come back.
    task automatic drain;
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Write block_count, then read it back for the checker to compare.
    task automatic set_block_count(input logic [CNT_W-1:0] count);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = BLOCK_COUNT_ADDR;
        pwdata = APB_DW'(count);
        @(negedge i_clk) penable = 1'b1;
        @(negedge i_clk) begin
            penable = 1'b0;
            pwrite = 1'b0;
        end
        @(negedge i_clk) penable = 1'b1;
        @(negedge i_clk) begin
            psel = 1'b0;
            penable = 1'b0;
        end
    endtask

    initial begin
        int unsigned phase_counts[6];
        int unsigned span;
        int unsigned alloc_pct;
        int unsigned top_blk;
        logic [CNT_W-1:0] count;
        logic op;
        logic [IDX_W-1:0] blk;

        phase_counts = '{2047, 1, 32, 33, 1024, 0};
        repeat (7) @(negedge i_clk);
        rst_n = 1'b1;

        // Directed: default count, fill from the bottom, reuse a freed hole,
        // free an already free block and the top block.
        repeat (4) send_request(CMD_ALLOC, IDX_W'($urandom));
        send_request(CMD_FREE, 10'd1);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, 10'd500);
        send_request(CMD_FREE, 10'd1023);
        drain();

        // Zero count: nothing can be allocated or freed.
        set_block_count('0);
        send_request(CMD_ALLOC, '1);
        send_request(CMD_FREE, '0);
        send_request(CMD_FREE, '1);
        drain();

        // Count above the bitmap size saturates.
        set_block_count('1);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, '1);
        drain();

        // Count lowered below blocks in use: full bitmap, then out-of-range free
        // of a used block, then reuse of a freed one.
        set_block_count(11'd3);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, 10'd3);
        send_request(CMD_FREE, 10'd2);
        send_request(CMD_ALLOC, '0);
        drain();

        // Raise the count again: the stranded blocks become visible.
        set_block_count(11'd1025);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, 10'd4);
        drain();

        // Random phases: mostly small counts so the bitmap fills and scans
        // stay short; extremes in the first few phases.
        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            if (phase < 6)
                count = CNT_W'(phase_counts[phase]);
            else if ($urandom_range(0, 3) == 0)
                count = CNT_W'($urandom_range(0, 2047));
            else
                count = CNT_W'($urandom_range(2, 96));
            set_block_count(count);
            span = (count > 1024) ? 1024 : count;
            top_blk = (span + 1 > 1023) ? 1023 : span + 1;
            alloc_pct = $urandom_range(35, 75);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);

            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                // Hold off now and then until the block is empty.
                if ($urandom_range(0, 39) == 0)
                    drain();
                op = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
                // Aim most frees at the managed range and just past it.
                if (span != 0 && $urandom_range(0, 4) != 0)
                    blk = IDX_W'($urandom_range(0, top_blk));
                else
                    blk = IDX_W'($urandom);
                send_request(op, blk);
            end
            drain();
        end

        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        drain();
        repeat (50) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: bitmap_block_allocator.f
hw/rtl/bba_pkg.sv
hw/rtl/bitmap_block_allocator.sv
bench/bba_grant_checker.sv
bench/testbench.sv
